/* hdl/cteb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cursor text edit buffer package
// Command codes, operation kinds and the request record that travels from
// the command decoder through the queue to the memory sequencer.
// ----------------------------------------------------------------------------
package cteb_pkg;

    // Command codes on the input channel.
    localparam logic [2:0] CMD_INSERT    = 3'd0;
    localparam logic [2:0] CMD_LEFT      = 3'd1;
    localparam logic [2:0] CMD_RIGHT     = 3'd2;
    localparam logic [2:0] CMD_BACKSPACE = 3'd3;
    localparam logic [2:0] CMD_READ      = 3'd4;

    // Field widths fixed by the interface.
    localparam int CharW = 8;
    localparam int PosW  = 10;
    localparam int CntW  = 11;

    // Memory work that one request needs in the back end.
    typedef enum logic [1:0] {
        OP_NONE,
        OP_WRITE,
        OP_MOVE,
        OP_READ
    } op_kind_t;

    // Back end sequencer states.
    typedef enum logic {
        BK_IDLE,
        BK_DATA
    } back_state_t;

    // Classified request: memory work plus the precomputed result fields.
    typedef struct packed {
        op_kind_t              kind;
        logic [CharW-1:0]      wr_data;
        logic [CntW-1:0]       cursor_pos;
        logic [CntW-1:0]       text_length;
        logic                  ignored;
    } req_info_t;

endpackage

/* hdl/cteb_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cursor text edit buffer front end
// Holds the cursor and length counts, classifies each accepted command and
// works out its memory addresses and result fields ahead of the back end.
// ----------------------------------------------------------------------------
module cteb_front #(
    parameter int CAPACITY = 1024
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    input  logic [2:0]                            command,
    input  logic [cteb_pkg::CharW-1:0]            char_in,
    input  logic [cteb_pkg::PosW-1:0]             read_pos,
    output cteb_pkg::req_info_t                   info,
    output logic [$clog2(CAPACITY)-1:0]           rd_addr,
    output logic [$clog2(CAPACITY)-1:0]           wr_addr
);
    import cteb_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = ((CW > PosW) ? CW : PosW) + 1;
    localparam int XW = (CW > CntW) ? CW : CntW;

    logic [CW-1:0] front_reg, front_next;
    logic [CW-1:0] back_reg, back_next;
    logic [CW-1:0] len;
    logic [CW-1:0] len_next;
    logic [PW-1:0] pos_x;
    logic [PW-1:0] len_x;
    logic [PW-1:0] front_x;
    logic [PW-1:0] tail_addr;
    logic [XW-1:0] front_ext;
    logic [XW-1:0] len_ext;
    op_kind_t      kind;
    logic          ign;

    assign len     = front_reg + back_reg;
    assign pos_x   = PW'(read_pos);
    assign len_x   = PW'(len);
    assign front_x = PW'(front_reg);
    // A position past the cursor maps into the top part: pos + (CAPACITY - len).
    assign tail_addr = pos_x + PW'(CAPACITY) - len_x;

    // Classify the command and compute the counts it leaves.
    always_comb
    begin
        kind       = OP_NONE;
        ign        = 1'b0;
        rd_addr    = '0;
        wr_addr    = '0;
        front_next = front_reg;
        back_next  = back_reg;
        unique case (command)
            CMD_INSERT:
            begin
                if (len == CW'(CAPACITY))
                begin
                    ign = 1'b1;
                end
                else
                begin
                    kind       = OP_WRITE;
                    wr_addr    = front_reg[AW-1:0];
                    front_next = front_reg + CW'(1);
                end
            end
            CMD_LEFT:
            begin
                if (front_reg == '0)
                begin
                    ign = 1'b1;
                end
                else
                begin
                    kind       = OP_MOVE;
                    rd_addr    = AW'(front_reg - CW'(1));
                    wr_addr    = AW'(CW'(CAPACITY - 1) - back_reg);
                    front_next = front_reg - CW'(1);
                    back_next  = back_reg + CW'(1);
                end
            end
            CMD_RIGHT:
            begin
                if (back_reg == '0)
                begin
                    ign = 1'b1;
                end
                else
                begin
                    kind       = OP_MOVE;
                    rd_addr    = AW'(CW'(CAPACITY) - back_reg);
                    wr_addr    = front_reg[AW-1:0];
                    front_next = front_reg + CW'(1);
                    back_next  = back_reg - CW'(1);
                end
            end
            CMD_BACKSPACE:
            begin
                if (front_reg == '0)
                begin
                    ign = 1'b1;
                end
                else
                begin
                    front_next = front_reg - CW'(1);
                end
            end
            CMD_READ:
            begin
                if (pos_x < front_x)
                begin
                    kind    = OP_READ;
                    rd_addr = AW'(pos_x);
                end
                else if (pos_x < len_x)
                begin
                    kind    = OP_READ;
                    rd_addr = AW'(tail_addr);
                end
                else
                begin
                    ign = 1'b1;
                end
            end
            default:
            begin
                ign = 1'b1;
            end
        endcase
    end

    assign len_next  = front_next + back_next;
    assign front_ext = XW'(front_next);
    assign len_ext   = XW'(len_next);

    // Result fields travel with the request.
    always_comb
    begin
        info.kind        = kind;
        info.wr_data     = char_in;
        info.cursor_pos  = front_ext[CntW-1:0];
        info.text_length = len_ext[CntW-1:0];
        info.ignored     = ign;
    end

    // Count registers advance on every accepted request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            back_reg  <= '0;
        end
        else if (push)
        begin
            front_reg <= front_next;
            back_reg  <= back_next;
        end
    end

endmodule

/* hdl/cteb_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cursor text edit buffer request queue
// Two-entry FIFO that decouples the command decoder from the memory
// sequencer so that each side can stall on its own.
// ----------------------------------------------------------------------------
module cteb_queue #(
    parameter int DW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [DW-1:0] push_data,
    input  logic          pop,
    output logic          full,
    output logic          not_empty,
    output logic [DW-1:0] head
);
    localparam int Depth = 2;

    logic [DW-1:0] entry_reg [Depth];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;

    assign full      = (count_reg == 2'(Depth));
    assign not_empty = (count_reg != 2'd0);
    assign head      = entry_reg[rd_ptr_reg];

    // Pointer and occupancy updates.
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hdl/cteb_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cursor text edit buffer back end
// Owns the text memory and carries out each queued request: a write, a
// read followed by a write, a read or no memory work, then loads the result register.
// ----------------------------------------------------------------------------
module cteb_back #(
    parameter int CAPACITY = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    input  cteb_pkg::req_info_t               q_info,
    input  logic [$clog2(CAPACITY)-1:0]       q_rd_addr,
    input  logic [$clog2(CAPACITY)-1:0]       q_wr_addr,
    output logic                              q_pop,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [cteb_pkg::CharW-1:0]        char_out,
    output logic [cteb_pkg::CntW-1:0]         cursor_pos,
    output logic [cteb_pkg::CntW-1:0]         text_length,
    output logic                              ignored
);
    import cteb_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic [CharW-1:0] mem [CAPACITY];
    logic [CharW-1:0] rdata_reg;

    back_state_t      state_reg, state_next;
    req_info_t        work_reg;
    logic [AW-1:0]    work_addr_reg;
    logic             work_load;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [CharW-1:0] mem_wdata;
    logic             mem_re;

    logic             out_valid_reg, out_valid_next;
    logic             out_load;
    req_info_t        load_info;
    logic [CharW-1:0] load_char;
    logic [CharW-1:0] char_out_reg;
    logic [CntW-1:0]  cursor_pos_reg;
    logic [CntW-1:0]  text_length_reg;
    logic             ignored_reg;
    logic             out_free;

    assign out_free = !out_valid_reg || !out_stall;

    // Sequencer: writes, backspaces and ignored requests finish at once, the rest wait for read data.
    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        work_load  = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = q_wr_addr;
        mem_wdata  = q_info.wr_data;
        mem_re     = 1'b0;
        out_load   = 1'b0;
        load_info  = q_info;
        load_char  = '0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_info.kind == OP_MOVE || q_info.kind == OP_READ)
                    begin
                        q_pop      = 1'b1;
                        mem_re     = 1'b1;
                        work_load  = 1'b1;
                        state_next = BK_DATA;
                    end
                    else if (out_free)
                    begin
                        q_pop    = 1'b1;
                        out_load = 1'b1;
                        mem_we   = (q_info.kind == OP_WRITE);
                    end
                end
            end
            BK_DATA:
            begin
                load_info = work_reg;
                mem_waddr = work_addr_reg;
                mem_wdata = rdata_reg;
                if (out_free)
                begin
                    out_load   = 1'b1;
                    mem_we     = (work_reg.kind == OP_MOVE);
                    load_char  = (work_reg.kind == OP_READ) ? rdata_reg : '0;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Result register valid flag.
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working request and result payload.
    always_ff @(posedge clk)
    begin
        if (work_load)
        begin
            work_reg      <= q_info;
            work_addr_reg <= q_wr_addr;
        end
        if (out_load)
        begin
            char_out_reg    <= load_char;
            cursor_pos_reg  <= load_info.cursor_pos;
            text_length_reg <= load_info.text_length;
            ignored_reg     <= load_info.ignored;
        end
    end

    // Text memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[q_rd_addr];
        end
    end

    assign out_valid   = out_valid_reg;
    assign char_out    = char_out_reg;
    assign cursor_pos  = cursor_pos_reg;
    assign text_length = text_length_reg;
    assign ignored     = ignored_reg;

endmodule

/* hdl/cursor_text_edit_buffer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cursor text edit buffer
// Gap-buffer line editor: text before the cursor fills the bottom of one
// byte memory, text after the cursor fills the top.
// ----------------------------------------------------------------------------
// Usage:
// Each request on the input channel (in_valid, in_stall) carries a command,
// a byte to insert and a position to read. Every request yields exactly one
// response on the output channel (out_valid, out_stall) with the byte read,
// the cursor position, the text length and an ignored flag.
// The decoder resolves a request in the cycle it is accepted and places it
// in a two-entry queue. The memory sequencer finishes inserts, backspaces
// and ignored commands from its idle state, and takes cursor moves and reads
// through its data state, since the text memory has one registered read port
// and its data must come back before the byte is written or returned. The
// sequencer takes no new request from the queue while a move or read waits
// in its data state.
// Reset empties the text and puts the cursor at zero; memory contents are
// not cleared. While out_stall is high the response holds, the sequencer
// waits to load the next response and in_stall rises once the queue fills.
// ----------------------------------------------------------------------------
module cursor_text_edit_buffer_top #(
    parameter int CAPACITY = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [2:0]                    command,
    input  logic [cteb_pkg::CharW-1:0]    char_in,
    input  logic [cteb_pkg::PosW-1:0]     read_pos,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [cteb_pkg::CharW-1:0]    char_out,
    output logic [cteb_pkg::CntW-1:0]     cursor_pos,
    output logic [cteb_pkg::CntW-1:0]     text_length,
    output logic                          ignored
);
    import cteb_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int IW = $bits(req_info_t);
    localparam int DW = IW + 2 * AW;

    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_valid;
    req_info_t     f_info;
    logic [AW-1:0] f_rd_addr;
    logic [AW-1:0] f_wr_addr;
    logic [DW-1:0] q_head;
    req_info_t     h_info;
    logic [AW-1:0] h_rd_addr;
    logic [AW-1:0] h_wr_addr;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    // Command decoder and count keeper.
    cteb_front #(
        .CAPACITY (CAPACITY)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .command  (command),
        .char_in  (char_in),
        .read_pos (read_pos),
        .info     (f_info),
        .rd_addr  (f_rd_addr),
        .wr_addr  (f_wr_addr)
    );

    // Request queue between decoder and sequencer.
    cteb_queue #(
        .DW (DW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({f_info, f_rd_addr, f_wr_addr}),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_valid),
        .head      (q_head)
    );

    assign {h_info, h_rd_addr, h_wr_addr} = q_head;

    // Memory sequencer and response register.
    cteb_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_info      (h_info),
        .q_rd_addr   (h_rd_addr),
        .q_wr_addr   (h_wr_addr),
        .q_pop       (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .char_out    (char_out),
        .cursor_pos  (cursor_pos),
        .text_length (text_length),
        .ignored     (ignored)
    );

    // The cursor never sits past the end of the text.
    a_cursor_in_text: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cursor_pos <= text_length))
        else $error("cursor beyond text length");

    // A response that was ignored never carries a byte.
    a_ignored_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ignored) |-> (char_out == '0))
        else $error("ignored response carries data");

    // The sequencer never pops an empty queue.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("queue popped while empty");

endmodule

/* verif/cursor_text_edit_buffer_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cursor text edit buffer testbench
// Drives edit requests into the gap-buffer line editor and checks every
// response against a cycle-free model of the text, the cursor and the length.
// A short table of directed requests covers the empty and boundary cases.
// Randomized traffic follows under changing idle patterns, with a long
// receiver hold-off and a burst that walks the cursor toward both ends.
// ----------------------------------------------------------------------------
module cursor_text_edit_buffer_top_tb;

    import cteb_pkg::*;

    localparam int CAPACITY      = 1024;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 10;
    localparam int LONG_HOLD     = 60;
    localparam int NUM_DIRECTED  = 25;
    localparam int RANDOM_ITEMS  = 130;
    localparam int PENDING_DEPTH = 16;

    // Codes outside the defined command set.
    localparam logic [2:0] CMD_UNKNOWN_FIRST = 3'd5;
    localparam logic [2:0] CMD_UNKNOWN_LAST  = 3'd7;

    // Bytes that name the commands of the classic editor exercise.
    localparam logic [CharW-1:0] CHAR_L = "L";
    localparam logic [CharW-1:0] CHAR_D = "D";
    localparam logic [CharW-1:0] CHAR_B = "B";
    localparam logic [CharW-1:0] CHAR_P = "P";

    typedef struct packed {
        logic [CharW-1:0] ch;
        logic [CntW-1:0]  cur;
        logic [CntW-1:0]  len;
        logic             ign;
    } edit_result_t;

    typedef struct packed {
        logic [2:0]       cmd;
        logic [CharW-1:0] ch;
        logic [PosW-1:0]  pos;
        logic             fixed;
        edit_result_t     res;
    } directed_row_t;

    // Directed requests; rows with fixed set carry their response typed in.
    localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{CMD_LEFT,          8'h00,  10'd0,   1'b1, '{8'h00, 11'd0, 11'd0, 1'b1}},
        '{CMD_RIGHT,         8'h00,  10'd0,   1'b1, '{8'h00, 11'd0, 11'd0, 1'b1}},
        '{CMD_BACKSPACE,     8'h00,  10'd0,   1'b1, '{8'h00, 11'd0, 11'd0, 1'b1}},
        '{CMD_READ,          8'h00,  10'd0,   1'b1, '{8'h00, 11'd0, 11'd0, 1'b1}},
        '{CMD_READ,          8'hFF,  10'h3FF, 1'b1, '{8'h00, 11'd0, 11'd0, 1'b1}},
        '{CMD_UNKNOWN_FIRST, 8'h00,  10'd0,   1'b1, '{8'h00, 11'd0, 11'd0, 1'b1}},
        '{CMD_UNKNOWN_LAST,  8'hFF,  10'h3FF, 1'b1, '{8'h00, 11'd0, 11'd0, 1'b1}},
        '{CMD_INSERT,        8'h00,  10'h3FF, 1'b1, '{8'h00, 11'd1, 11'd1, 1'b0}},
        '{CMD_INSERT,        8'hFF,  10'd0,   1'b1, '{8'h00, 11'd2, 11'd2, 1'b0}},
        '{CMD_INSERT,        CHAR_L, 10'd0,   1'b1, '{8'h00, 11'd3, 11'd3, 1'b0}},
        '{CMD_INSERT,        CHAR_D, 10'd0,   1'b1, '{8'h00, 11'd4, 11'd4, 1'b0}},
        '{CMD_READ,          8'hFF,  10'd0,   1'b1, '{8'h00, 11'd4, 11'd4, 1'b0}},
        '{CMD_READ,          8'h00,  10'd1,   1'b1, '{8'hFF, 11'd4, 11'd4, 1'b0}},
        '{CMD_LEFT,          8'h00,  10'd0,   1'b1, '{8'h00, 11'd3, 11'd4, 1'b0}},
        '{CMD_LEFT,          8'h00,  10'd0,   1'b1, '{8'h00, 11'd2, 11'd4, 1'b0}},
        '{CMD_READ,          8'h00,  10'd3,   1'b0, '0},
        '{CMD_READ,          8'h00,  10'd4,   1'b1, '{8'h00, 11'd2, 11'd4, 1'b1}},
        '{CMD_RIGHT,         8'h00,  10'd0,   1'b0, '0},
        '{CMD_BACKSPACE,     8'h00,  10'd0,   1'b0, '0},
        '{CMD_INSERT,        CHAR_B, 10'd2,   1'b0, '0},
        '{CMD_INSERT,        CHAR_P, 10'h3FF, 1'b0, '0},
        '{CMD_READ,          8'h00,  10'd2,   1'b0, '0},
        '{CMD_UNKNOWN_FIRST, 8'hFF,  10'h3FF, 1'b0, '0},
        '{CMD_RIGHT,         8'h00,  10'd0,   1'b0, '0},
        '{CMD_RIGHT,         8'h00,  10'd0,   1'b0, '0}
    };

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    logic [2:0]       command   = CMD_INSERT;
    logic [CharW-1:0] char_in   = '0;
    logic [PosW-1:0]  read_pos  = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [CharW-1:0] char_out;
    logic [CntW-1:0]  cursor_pos;
    logic [CntW-1:0]  text_length;
    logic             ignored;

    // Mirror of the editor: gap buffer contents and the two run lengths.
    logic [CharW-1:0] text_mirror [CAPACITY];
    int               front_len = 0;
    int               back_len  = 0;

    // Ring of expected responses; the sender writes, the checker reads.
    edit_result_t     expected_ring [PENDING_DEPTH];
    int               expected_wr    = 0;
    int               expected_rd    = 0;
    int               mismatch_count = 0;
    int               cycle_count    = 0;
    int               send_idle_pct  = 0;
    int               recv_stall_pct = 0;
    int               hold_requests  = 0;
    int               hold_seen      = 0;
    int               hold_left      = 0;

    cursor_text_edit_buffer_top #(
        .CAPACITY(CAPACITY)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .command(command),
        .char_in(char_in),
        .read_pos(read_pos),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .char_out(char_out),
        .cursor_pos(cursor_pos),
        .text_length(text_length),
        .ignored(ignored)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Apply one edit to the mirror and return the response it must produce.
    task automatic apply_edit(input logic [2:0] cmd, input logic [CharW-1:0] ch,
                              input logic [PosW-1:0] pos, output edit_result_t res);
        int total;
        total = front_len + back_len;
        res = '0;
        case (cmd)
            CMD_INSERT:
                if (total >= CAPACITY)
                    res.ign = 1'b1;
                else
                begin
                    text_mirror[front_len] = ch;
                    front_len++;
                end
            CMD_LEFT:
                if (front_len == 0)
                    res.ign = 1'b1;
                else
                begin
                    front_len--;
                    text_mirror[CAPACITY - 1 - back_len] = text_mirror[front_len];
                    back_len++;
                end
            CMD_RIGHT:
                if (back_len == 0)
                    res.ign = 1'b1;
                else
                begin
                    text_mirror[front_len] = text_mirror[CAPACITY - back_len];
                    back_len--;
                    front_len++;
                end
            CMD_BACKSPACE:
                if (front_len == 0)
                    res.ign = 1'b1;
                else
                    front_len--;
            CMD_READ:
                if (pos < front_len)
                    res.ch = text_mirror[pos];
                else if (pos < total)
                    res.ch = text_mirror[CAPACITY - back_len + (pos - front_len)];
                else
                    res.ign = 1'b1;
            default:
                res.ign = 1'b1;
        endcase
        res.cur = CntW'(front_len);
        res.len = CntW'(front_len + back_len);
    endtask

    // Offer one request, hold it until accepted, then queue its response.
    task automatic send_request(input logic [2:0] cmd, input logic [CharW-1:0] ch,
                                input logic [PosW-1:0] pos, input logic fixed,
                                input edit_result_t fixed_res);
        edit_result_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        char_in  <= ch;
        read_pos <= pos;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        apply_edit(cmd, ch, pos, predicted);
        expected_ring[expected_wr % PENDING_DEPTH] = fixed ? fixed_res : predicted;
        expected_wr++;
    endtask

    // Random edit with a mix that keeps the text growing slowly.
    task automatic send_random_edit();
        int               roll;
        int               total;
        logic [2:0]       cmd;
        logic [PosW-1:0]  pos;
        roll  = $urandom_range(0, 99);
        total = front_len + back_len;
        if (roll < 35)
            cmd = CMD_INSERT;
        else if (roll < 50)
            cmd = CMD_LEFT;
        else if (roll < 65)
            cmd = CMD_RIGHT;
        else if (roll < 75)
            cmd = CMD_BACKSPACE;
        else if (roll < 95)
            cmd = CMD_READ;
        else
            cmd = 3'($urandom_range(CMD_UNKNOWN_FIRST, CMD_UNKNOWN_LAST));
        // Reads mostly land inside the text, the rest anywhere.
        if (total > 0 && $urandom_range(0, 9) < 7)
            pos = PosW'($urandom_range(0, total - 1));
        else
            pos = PosW'($urandom_range(0, 1023));
        send_request(cmd, CharW'($urandom_range(0, 255)), pos, 1'b0, '0);
    endtask

    // Stop offering and wait until every queued response has arrived.
    task automatic wait_for_responses();
        in_valid <= 1'b0;
        while (expected_wr != expected_rd)
            @(posedge clk);
    endtask

    // Compare one response field and log a mismatch.
    task automatic check_field(input string name, input logic [CntW-1:0] want,
                               input logic [CntW-1:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_seen != hold_requests)
        begin
            hold_seen <= hold_requests;
            hold_left <= LONG_HOLD;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Response checker.
    always @(posedge clk)
    begin
        edit_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_wr == expected_rd)
            begin
                mismatch_count++;
                $display("%0t: unexpected response, expected none, actual %0h %0h %0h %0h",
                         $time, char_out, cursor_pos, text_length, ignored);
            end
            else
            begin
                want = expected_ring[expected_rd % PENDING_DEPTH];
                expected_rd++;
                check_field("char_out", CntW'(want.ch), CntW'(char_out));
                check_field("cursor_pos", want.cur, cursor_pos);
                check_field("text_length", want.len, text_length);
                check_field("ignored", CntW'(want.ign), CntW'(ignored));
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: empty buffer, boundaries and a small edit session.
        for (int i = 0; i < NUM_DIRECTED; i++)
            send_request(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].ch, DIRECTED_ROWS[i].pos,
                         DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].res);
        wait_for_responses();

        // Sender mostly busy, receiver mostly stalled.
        send_idle_pct = 7;
        recv_stall_pct <= 71;
        repeat (RANDOM_ITEMS) send_random_edit();
        wait_for_responses();

        // Sender mostly idle, receiver mostly ready.
        send_idle_pct = 71;
        recv_stall_pct <= 7;
        repeat (RANDOM_ITEMS) send_random_edit();
        wait_for_responses();

        // No idling; a long receiver hold-off backs up the input.
        send_idle_pct = 0;
        recv_stall_pct <= 0;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 10)
                hold_requests <= hold_requests + 1;
            send_random_edit();
        end
        wait_for_responses();

        // Walk the cursor toward both ends and read around them.
        repeat (4) send_request(CMD_LEFT, 8'h00, 10'd0, 1'b0, '0);
        send_request(CMD_READ, 8'h00, 10'h3FF, 1'b0, '0);
        repeat (4) send_request(CMD_READ, 8'h00, PosW'($urandom_range(0, 1023)), 1'b0, '0);
        repeat (8) send_request(CMD_RIGHT, 8'h00, 10'd0, 1'b0, '0);
        send_request(CMD_READ, 8'h00, PosW'(front_len + back_len), 1'b0, '0);
        repeat (4) send_request(CMD_BACKSPACE, 8'h00, 10'd0, 1'b0, '0);
        repeat (4) send_request(CMD_INSERT, CharW'($urandom_range(0, 255)), 10'd0, 1'b0, '0);
        wait_for_responses();

        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
